/* hw/rtl/time_signal_pulse_slicer_defines.svh */
// Assertion helpers shared by the slicer RTL.
`ifndef TIME_SIGNAL_PULSE_SLICER_DEFINES_SVH
`define TIME_SIGNAL_PULSE_SLICER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSPS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TSPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tsps_pkg.sv */
`default_nettype none

package tsps_pkg;

  localparam int AMP_W       = 20;
  localparam int AMP_BUS_W   = 24;
  localparam int PEAK_W      = 19;
  localparam int HIST_W      = 32;
  localparam int PH_W        = 32;
  localparam int PH_FRAC_W   = 30;
  localparam int CORR_W      = 22;
  localparam int INC_W       = 25;
  localparam int OFS_W       = 30;
  localparam int DECAY_W     = 9;
  localparam int CLS_W       = 3;
  localparam int SYM_W       = 2;
  localparam int FRAME_W     = 60;
  localparam int FRAME_LEN_W = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 30;
  localparam int OUT_USER_W  = 3;
  localparam int OUT_DATA_W  = 72;

  localparam int MAX_FRAME_BITS_DEF = 60;
  localparam int FRAME_MIN          = 59;

  localparam int DECAY_PERIOD = 400;
  localparam int DECAY_MUL    = 4055;

  localparam logic [HIST_W-1:0] TICK_PATTERN = 32'hffff0000;

  localparam logic [INC_W-1:0] PH_INC_RST   = 25'd134217;
  localparam logic [OFS_W-1:0] TICK_OFS_RST = 30'd2147472;

  localparam int PH_FULL  = 32'h40000000;
  localparam int PH_NUDGE = 32'h00400000;
  localparam int FC_NUDGE = 16;
  localparam int FC_LIMIT = 32'h00100000;
  localparam int PH_5PCT  = PH_FULL / 100 * 5;
  localparam int PH_15PCT = PH_FULL / 100 * 15;
  localparam int PH_25PCT = PH_FULL / 100 * 25;
  localparam int PH_30PCT = PH_FULL / 100 * 30;

  // pulse class register codes
  localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_SHORT = 3'd1;
  localparam logic [CLS_W-1:0] CLS_LONG  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_DONE  = 3'd4;

  // symbol codes on the result
  localparam logic [SYM_W-1:0] SYM_NONE  = 2'd0;
  localparam logic [SYM_W-1:0] SYM_SHORT = 2'd1;
  localparam logic [SYM_W-1:0] SYM_LONG  = 2'd2;
  localparam logic [SYM_W-1:0] SYM_BAD   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PH_INC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_OFS = 2'd1;

  typedef struct packed {
    logic tick;
    logic rise;
  } slice_t;

  typedef struct packed {
    logic             sym_valid;
    logic [SYM_W-1:0] sym;
  } sym_t;

endpackage

`default_nettype wire

/* hw/rtl/tsps_slicer.sv */
`default_nettype none

module tsps_slicer
  import tsps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire logic signed [AMP_W-1:0] amplitude,
  output slice_t                       slice
);

  logic [PEAK_W-1:0]    peak_r, peak_nxt;
  logic [HIST_W-1:0]    hist_r, hist_nxt;
  logic [DECAY_W-1:0]   peak_age_r, peak_age_nxt;
  logic [DECAY_W:0]     decay_inc;
  logic [30:0]          pk_prod;
  logic [PEAK_W-1:0]    pk_dec;
  logic signed [21:0]   si_x, pk_x, diff, thr_hi, thr_lo, pk_sum;
  logic [PEAK_W+1:0]    pk3;

  always_comb begin
    decay_inc = {1'b0, peak_age_r} + 10'd1;
    pk_prod   = 31'(peak_r) * 31'(DECAY_MUL);
    if (decay_inc >= 10'(DECAY_PERIOD)) begin
      peak_age_nxt = '0;
      pk_dec       = pk_prod[30:12];
    end else begin
      peak_age_nxt = decay_inc[DECAY_W-1:0];
      pk_dec       = peak_r;
    end

    si_x   = {{2{amplitude[AMP_W-1]}}, amplitude};
    pk_x   = {3'b000, pk_dec};
    diff   = si_x - pk_x;
    pk_sum = pk_x + (diff >>> 4);
    if (si_x > 22'sd0 && si_x > pk_x) begin
      peak_nxt = pk_sum[PEAK_W-1:0];
    end else begin
      peak_nxt = pk_dec;
    end

    pk3    = {1'b0, peak_nxt, 1'b0} + {2'b00, peak_nxt};
    thr_hi = {3'b000, pk3[PEAK_W+1:2]};
    thr_lo = {4'b0000, peak_nxt[PEAK_W-1:1]};

    hist_nxt = {hist_r[HIST_W-2:0], hist_r[0]};
    if (si_x > thr_hi) begin
      hist_nxt[0] = 1'b1;
    end else if (si_x < thr_lo) begin
      hist_nxt[0] = 1'b0;
    end

    slice.tick = (hist_nxt == TICK_PATTERN);
    slice.rise = (hist_nxt[1:0] == 2'b01);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r     <= '0;
      hist_r     <= '0;
      peak_age_r <= '0;
    end else if (step) begin
      peak_r     <= peak_nxt;
      hist_r     <= hist_nxt;
      peak_age_r <= peak_age_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tsps_phase.sv */
`default_nettype none

module tsps_phase
  import tsps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [INC_W-1:0] phase_increment,
  input  wire logic [OFS_W-1:0] tick_offset,
  input  wire slice_t           slice,
  output sym_t                  symb
);

  logic [PH_W-1:0]          phase_r, phase_nxt;
  logic signed [CORR_W-1:0] corr_r, corr_nxt;
  logic [CLS_W-1:0]         cls_r, cls_nxt;
  logic [PH_W-1:0]          ph1, ph2, ofs_diff;
  logic signed [CORR_W:0]   c_sum;
  logic signed [PH_W-1:0]   ph;
  logic                     wrap;

  always_comb begin
    wrap    = !phase_r[31] && phase_r[30];
    cls_nxt = cls_r;
    ph1     = phase_r;
    if (wrap) begin
      ph1     = {2'b00, phase_r[PH_FRAC_W-1:0]} + {{(PH_W-CORR_W){corr_r[CORR_W-1]}}, corr_r};
      cls_nxt = CLS_NONE;
    end

    ofs_diff = ph1 - {2'b00, tick_offset};
    ph2      = ph1;
    c_sum    = {corr_r[CORR_W-1], corr_r};
    if (slice.tick) begin
      if (!ofs_diff[PH_FRAC_W-1]) begin
        ph2   = ph1 - 32'(PH_NUDGE);
        c_sum = {corr_r[CORR_W-1], corr_r} - 23'(FC_NUDGE);
      end else begin
        ph2   = ph1 + 32'(PH_NUDGE);
        c_sum = {corr_r[CORR_W-1], corr_r} + 23'(FC_NUDGE);
      end
    end
    if (c_sum > FC_LIMIT) begin
      corr_nxt = CORR_W'(FC_LIMIT);
    end else if (c_sum < -FC_LIMIT) begin
      corr_nxt = CORR_W'(-FC_LIMIT);
    end else begin
      corr_nxt = c_sum[CORR_W-1:0];
    end

    ph = $signed(ph2);
    if (cls_nxt == CLS_NONE && slice.rise) begin
      if (ph >= PH_5PCT && ph <= PH_15PCT) begin
        cls_nxt = CLS_SHORT;
      end else if (ph >= PH_15PCT && ph <= PH_25PCT) begin
        cls_nxt = CLS_LONG;
      end
    end

    symb.sym_valid = 1'b0;
    symb.sym       = SYM_NONE;
    if (!cls_nxt[2] && ph >= PH_30PCT) begin
      symb.sym_valid = 1'b1;
      symb.sym       = cls_nxt[SYM_W-1:0];
      cls_nxt        = CLS_DONE;
    end

    phase_nxt = ph2 + {{(PH_W-INC_W){1'b0}}, phase_increment};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      corr_r  <= '0;
      cls_r   <= CLS_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      corr_r  <= corr_nxt;
      cls_r   <= cls_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tsps_frame.sv */
`default_nettype none
`include "time_signal_pulse_slicer_defines.svh"

module tsps_frame
  import tsps_pkg::*;
#(
  parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire sym_t                   symb,
  output logic                        frame_valid,
  output logic [FRAME_W-1:0]          frame_bits,
  output logic [FRAME_LEN_W-1:0]      frame_length
);

  localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);
  localparam int IDX_W = $clog2(MAX_FRAME_BITS);

  logic [MAX_FRAME_BITS-1:0] store_r, store_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  always_comb begin
    store_nxt    = store_r;
    cnt_nxt      = cnt_r;
    frame_valid  = 1'b0;
    frame_bits   = '0;
    frame_length = '0;
    if (symb.sym_valid) begin
      if (symb.sym == SYM_NONE) begin
        if (cnt_r >= CNT_W'(FRAME_MIN)) begin
          frame_valid  = 1'b1;
          frame_bits   = FRAME_W'(store_r);
          frame_length = FRAME_LEN_W'(cnt_r);
        end
        store_nxt = '0;
        cnt_nxt   = '0;
      end else if (cnt_r < CNT_W'(MAX_FRAME_BITS)) begin
        if (symb.sym == SYM_LONG) begin
          store_nxt[cnt_r[IDX_W-1:0]] = 1'b1;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      store_r <= store_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `TSPS_ASSERT(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_FRAME_BITS), "bit count past frame size")
  `TSPS_ASSERT(a_frame_len, frame_valid, cnt_r >= CNT_W'(FRAME_MIN), "short frame released")
  `TSPS_ASSERT_NEXT(a_clear, step && symb.sym_valid && symb.sym == SYM_NONE,
                    cnt_r == '0, "frame not cleared on gap")

endmodule

`default_nettype wire

/* hw/rtl/time_signal_pulse_slicer.sv */
// Channel  | Ports                        | Transaction
// ---------+------------------------------+-------------------------------------
// in       | in_tvalid/in_tready/in_tdata | one amplitude sample
// out      | out_tvalid/out_tready/       | one result per sample
//          | out_tuser/out_tdata          |
// cfg      | cfg_valid/cfg_ready          | one register write, ready out of reset
//
// One sample per cycle sustained while out_tready is high: the input
// register feeds the combinational slicer/phase/frame update, which is
// registered into the result register. rst_n is synchronous, clears all
// tracker state and loads the register defaults; in_tready and cfg_ready
// stay low in reset. A stalled result holds the input register; input is
// ready while the input or result register is empty or the result drains.
`default_nettype none
`include "time_signal_pulse_slicer_defines.svh"

module time_signal_pulse_slicer
  import tsps_pkg::*;
#(
  parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [AMP_BUS_W-1:0]  in_tdata,   // [19:0] amplitude
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_USER_W-1:0]      out_tuser,  // [0] tick_seen, [1] symbol_valid,
                                                 // [2] frame_valid
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [1:0] symbol, [61:2] frame_bits,
                                                 // [67:62] frame_length
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                    in_vld_r;
  logic signed [AMP_W-1:0] amp_r;
  logic                    out_vld_r;
  logic [OUT_USER_W-1:0]   out_user_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [INC_W-1:0]        ph_inc_r;
  logic [OFS_W-1:0]        tick_ofs_r;
  logic                    step;
  slice_t                  slice;
  sym_t                    symb;
  logic                    frame_valid;
  logic [FRAME_W-1:0]      frame_bits;
  logic [FRAME_LEN_W-1:0]  frame_length;

  assign step       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = rst_n && (!in_vld_r || step);
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_inc_r   <= PH_INC_RST;
      tick_ofs_r <= TICK_OFS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PH_INC:   ph_inc_r   <= cfg_data[INC_W-1:0];
        CFG_TICK_OFS: tick_ofs_r <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      amp_r <= $signed(in_tdata[AMP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_user_r <= {frame_valid, symb.sym_valid, slice.tick};
      out_data_r <= {{(OUT_DATA_W - FRAME_LEN_W - FRAME_W - SYM_W){1'b0}},
                     frame_length, frame_bits, symb.sym};
    end
  end

  tsps_slicer u_slicer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .amplitude (amp_r),
    .slice     (slice)
  );

  tsps_phase u_phase (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .phase_increment (ph_inc_r),
    .tick_offset     (tick_ofs_r),
    .slice           (slice),
    .symb            (symb)
  );

  tsps_frame #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .symb         (symb),
    .frame_valid  (frame_valid),
    .frame_bits   (frame_bits),
    .frame_length (frame_length)
  );

  `TSPS_ASSERT_NEXT(a_step_out, step, out_vld_r, "result not loaded after step")
  `TSPS_ASSERT(a_frame_sym, out_vld_r && out_user_r[2],
               out_user_r[1] && out_data_r[1:0] == SYM_NONE, "frame without gap symbol")
  `TSPS_ASSERT(a_sym_code, out_vld_r, out_data_r[1:0] != SYM_BAD, "illegal symbol code")
  `TSPS_ASSERT(a_sym_idle, out_vld_r && !out_user_r[1], out_data_r[1:0] == SYM_NONE,
               "symbol set without symbol_valid")

endmodule

`default_nettype wire
